// ===== src/sxfp_pkg.sv =====
`timescale 1ns / 1ps
package sxfp_pkg;

  localparam int WIN_DEPTH = 12;
  localparam int FILL_W    = 4;
  localparam int IDX_W     = 4;

  localparam logic [7:0] SYNC_HI    = 8'hAA;
  localparam logic [7:0] SYNC_LO    = 8'h55;
  localparam logic [7:0] TYPE_WHEEL = 8'h01;
  localparam logic [7:0] TYPE_GAIN  = 8'h03;

  localparam int WHEEL_LEN = 12;
  localparam int GAIN_LEN  = 10;
  localparam int MIN_CHECK = 10;

  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(WIN_DEPTH);
  localparam logic [FILL_W-1:0] FILL_MIN   = FILL_W'(MIN_CHECK);
  localparam logic [FILL_W-1:0] FILL_WHEEL = FILL_W'(WHEEL_LEN);
  localparam logic [FILL_W-1:0] FILL_GAIN  = FILL_W'(GAIN_LEN);

  // index of the last data byte, covered by the final XOR step
  localparam logic [IDX_W-1:0] WHEEL_LAST = IDX_W'(WHEEL_LEN - 2);
  localparam logic [IDX_W-1:0] GAIN_LAST  = IDX_W'(GAIN_LEN - 2);

  localparam logic KIND_WHEEL = 1'b0;
  localparam logic KIND_GAIN  = 1'b1;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       append;
    logic       drop_one;
    logic       drop_frame;
    logic       frame_gain;
    logic [7:0] data;
  } win_cmd_t;

  typedef struct packed {
    logic load;
    logic kind;
  } emit_t;

endpackage

// ===== src/sxfp_window.sv =====
`timescale 1ns / 1ps
module sxfp_window (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sxfp_pkg::win_cmd_t         cmd,
  output sxfp_pkg::win_t             win,
  output logic [sxfp_pkg::FILL_W-1:0] fill
);
  import sxfp_pkg::*;

  win_t              bytes_r, bytes_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  always_comb begin
    bytes_nxt = bytes_r;
    fill_nxt  = fill_r;
    if (cmd.append) begin
      if (fill_r >= FILL_FULL) begin
        // discard the oldest byte to make room
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          bytes_nxt[i] = bytes_r[i+1];
        end
        bytes_nxt[WIN_DEPTH-1] = cmd.data;
      end else begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          if (fill_r == FILL_W'(i)) begin
            bytes_nxt[i] = cmd.data;
          end
        end
        fill_nxt = fill_r + 1'b1;
      end
    end else if (cmd.drop_one) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        bytes_nxt[i] = bytes_r[i+1];
      end
      fill_nxt = (fill_r == '0) ? '0 : fill_r - 1'b1;
    end else if (cmd.drop_frame) begin
      if (!cmd.frame_gain || fill_r <= FILL_GAIN) begin
        fill_nxt = '0;
      end else begin
        for (int i = 0; i < WIN_DEPTH - GAIN_LEN; i++) begin
          bytes_nxt[i] = bytes_r[i+GAIN_LEN];
        end
        fill_nxt = fill_r - FILL_GAIN;
      end
    end
  end

  assign win  = bytes_r;
  assign fill = fill_r;

endmodule

// ===== src/sxfp_ctrl.sv =====
`timescale 1ns / 1ps
module sxfp_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [7:0]                  in_rx_byte,
  input  sxfp_pkg::win_t              win,
  input  logic [sxfp_pkg::FILL_W-1:0] fill,
  input  logic                        out_free,
  output logic                        in_stall,
  output sxfp_pkg::win_cmd_t          cmd,
  output sxfp_pkg::emit_t             emit
);
  import sxfp_pkg::*;

  state_t           state_r, state_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             gain_r, gain_nxt;

  logic [7:0] sum_x;
  logic [7:0] chk_byte;
  logic       sum_last;

  // shared XOR unit: one window byte per cycle
  assign sum_x    = acc_r ^ win[idx_r];
  assign chk_byte = gain_r ? win[GAIN_LEN-1] : win[WHEEL_LEN-1];
  assign sum_last = (idx_r == (gain_r ? GAIN_LAST : WHEEL_LAST));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    idx_r  <= idx_nxt;
    gain_r <= gain_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    gain_nxt  = gain_r;
    cmd       = '0;
    cmd.data  = in_rx_byte;
    cmd.frame_gain = gain_r;
    emit      = '0;
    emit.kind = gain_r;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.append = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        acc_nxt = '0;
        idx_nxt = '0;
        if (fill < FILL_MIN) begin
          state_nxt = ST_IDLE;
        end else if (win[0] == SYNC_HI && win[1] == SYNC_LO && win[2] == TYPE_WHEEL) begin
          gain_nxt = KIND_WHEEL;
          // hold a short wheel frame until more bytes arrive
          state_nxt = (fill < FILL_WHEEL) ? ST_IDLE : ST_SUM;
        end else if (win[0] == SYNC_HI && win[1] == SYNC_LO && win[2] == TYPE_GAIN) begin
          gain_nxt  = KIND_GAIN;
          state_nxt = ST_SUM;
        end else begin
          cmd.drop_one = 1'b1;
        end
      end
      ST_SUM: begin
        if (sum_last) begin
          if (sum_x == chk_byte) begin
            state_nxt = ST_EMIT;
          end else begin
            cmd.drop_one = 1'b1;
            state_nxt    = ST_CHECK;
          end
        end else begin
          acc_nxt = sum_x;
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit.load      = 1'b1;
          cmd.drop_frame = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/sync_xor_frame_parser.sv =====
`timescale 1ns / 1ps
// channel | ports                                          | dir
// in      | in_valid, in_stall, in_rx_byte                 | byte in
// out     | out_valid, out_stall, out_frame_kind,          | frame out
//         | out_word_a, out_word_b, out_word_c, out_word_d |
// Each byte is appended, then the head is checked; with under 10 bytes in the window
// nothing more follows. A checksum walk steps one byte at a time through the single
// XOR unit, and a match ends in an emit; up to three checks per byte.
// rst_n (synchronous) empties the window; window bytes are not reset.
// A result waits in the output register; a new frame stalls while it is full and out_stall holds it.
module sync_xor_frame_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_kind,
  output logic signed [15:0] out_word_a,
  output logic signed [15:0] out_word_b,
  output logic signed [15:0] out_word_c,
  output logic signed [15:0] out_word_d
);
  import sxfp_pkg::*;

  win_t              win;
  logic [FILL_W-1:0] fill;
  win_cmd_t          cmd;
  emit_t             emit;
  logic              out_free;

  logic               out_valid_r, out_valid_nxt;
  logic               kind_r;
  logic signed [15:0] word_a_r, word_b_r, word_c_r, word_d_r;

  sxfp_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .win   (win),
    .fill  (fill)
  );

  sxfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .win        (win),
    .fill       (fill),
    .out_free   (out_free),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .emit       (emit)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      kind_r   <= emit.kind;
      word_a_r <= {win[3], win[4]};
      word_b_r <= {win[5], win[6]};
      word_c_r <= {win[7], win[8]};
      word_d_r <= (emit.kind == KIND_GAIN) ? 16'sd0 : {win[9], win[10]};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_kind = kind_r;
  assign out_word_a     = word_a_r;
  assign out_word_b     = word_b_r;
  assign out_word_c     = word_c_r;
  assign out_word_d     = word_d_r;

endmodule

// ===== src/sxfp_checker.sv =====
`timescale 1ns / 1ps
module sxfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_frame_kind,
  input logic signed [15:0] out_word_a,
  input logic signed [15:0] out_word_d
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_a) && $stable(out_frame_kind))
    else $error("stalled result changed");

  // every accepted byte is processed, with in_stall high in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("byte accepted without processing");

  // gain frames carry no fourth word
  a_gain_word_d: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_kind |-> out_word_d == 16'sd0)
    else $error("gain frame with nonzero fourth word");

  // a new result only appears out of byte processing
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without processing");

endmodule

bind sync_xor_frame_parser sxfp_checker u_sxfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_frame_kind (out_frame_kind),
  .out_word_a     (out_word_a),
  .out_word_d     (out_word_d)
);

// ===== verif/sync_xor_frame_parser_checker.sv =====
`timescale 1ns / 1ps
module sync_xor_frame_parser_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_frame_kind,
  input  logic signed [15:0] out_word_a,
  input  logic signed [15:0] out_word_b,
  input  logic signed [15:0] out_word_c,
  input  logic signed [15:0] out_word_d,
  output int                 fail_count,
  output int                 frames_due
);
  import sxfp_pkg::*;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] word_a;
    logic signed [15:0] word_b;
    logic signed [15:0] word_c;
    logic signed [15:0] word_d;
  } frame_t;

  logic [7:0]  win [WIN_DEPTH];
  int unsigned fill;
  frame_t      frame_q [$];

  function automatic void shift_out(input int unsigned n);
    if (n >= fill) begin
      fill = 0;
    end else begin
      for (int i = 0; i + n < WIN_DEPTH; i++) win[i] = win[i + n];
      fill -= n;
    end
  endfunction

  function automatic logic [7:0] xor_head(input int unsigned len);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < len; i++) acc ^= win[i];
    return acc;
  endfunction

  // Append one byte and rescan the head; at most one frame comes out.
  function automatic void parse_byte(input logic [7:0] b, output bit hit, output frame_t f);
    bit done;
    bit synced;
    hit  = 1'b0;
    f    = '0;
    done = 1'b0;
    if (fill >= WIN_DEPTH) shift_out(1);
    win[fill] = b;
    fill++;
    while (!done && fill >= MIN_CHECK) begin
      synced = (win[0] == SYNC_HI) && (win[1] == SYNC_LO);
      if (synced && win[2] == TYPE_WHEEL && fill < WHEEL_LEN) begin
        done = 1'b1;
      end else if (synced && win[2] == TYPE_WHEEL &&
                   xor_head(WHEEL_LEN - 1) == win[WHEEL_LEN - 1]) begin
        f = '{KIND_WHEEL, {win[3], win[4]}, {win[5], win[6]},
              {win[7], win[8]}, {win[9], win[10]}};
        hit  = 1'b1;
        done = 1'b1;
        shift_out(WHEEL_LEN);
      end else if (synced && win[2] == TYPE_GAIN &&
                   xor_head(GAIN_LEN - 1) == win[GAIN_LEN - 1]) begin
        f = '{KIND_GAIN, {win[3], win[4]}, {win[5], win[6]}, {win[7], win[8]}, 16'sd0};
        hit  = 1'b1;
        done = 1'b1;
        shift_out(GAIN_LEN);
      end else begin
        shift_out(1);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic signed [16:0] exp_v,
                                      input logic signed [16:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: frame field %s mismatch: expected %0d, actual %0d",
               $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    frame_t next_f;
    frame_t exp_f;
    bit     hit;
    if (!rst_n) begin
      fill       = 0;
      frame_q.delete();
      fail_count = 0;
      frames_due = 0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(in_rx_byte, hit, next_f);
        if (hit) frame_q.push_back(next_f);
      end
      if (out_valid && !out_stall) begin
        if (frame_q.size() == 0) begin
          $display("%0t: unexpected frame: expected none, actual kind %0d words %0d %0d %0d %0d",
                   $time, out_frame_kind, out_word_a, out_word_b, out_word_c, out_word_d);
          fail_count++;
        end else begin
          exp_f = frame_q.pop_front();
          check_field("frame_kind", 17'(exp_f.kind), 17'(out_frame_kind));
          check_field("word_a", 17'(exp_f.word_a), 17'(out_word_a));
          check_field("word_b", 17'(exp_f.word_b), 17'(out_word_b));
          check_field("word_c", 17'(exp_f.word_c), 17'(out_word_c));
          check_field("word_d", 17'(exp_f.word_d), 17'(out_word_d));
        end
      end
      frames_due = frame_q.size();
    end
  end

endmodule

// ===== verif/sync_xor_frame_parser_tb.sv =====
`timescale 1ns / 1ps
module sync_xor_frame_parser_tb;
  import sxfp_pkg::*;

  localparam int BYTE_TARGET  = 450;
  localparam int MAX_GAP      = 12;
  localparam int HOLD_AT      = 6;
  localparam int HOLD_CYCLES  = 800;
  localparam int DRAIN_CYCLES = 100;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_stall  = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               out_frame_kind;
  logic signed [15:0] out_word_a;
  logic signed [15:0] out_word_b;
  logic signed [15:0] out_word_c;
  logic signed [15:0] out_word_d;
  int                 fail_count;
  int                 frames_due;

  logic [7:0]  tx_q [$];
  logic [7:0]  frame_buf [$];
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int          bytes_sent = 0;
  int          frames_taken = 0;
  logic [15:0] corner_words [4] = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
  logic [7:0]  marker_bytes [4] = '{SYNC_HI, SYNC_LO, TYPE_WHEEL, TYPE_GAIN};

  sync_xor_frame_parser uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_kind (out_frame_kind),
    .out_word_a     (out_word_a),
    .out_word_b     (out_word_b),
    .out_word_c     (out_word_c),
    .out_word_d     (out_word_d)
  );

  sync_xor_frame_parser_checker frame_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_kind (out_frame_kind),
    .out_word_a     (out_word_a),
    .out_word_b     (out_word_b),
    .out_word_c     (out_word_c),
    .out_word_d     (out_word_d),
    .fail_count     (fail_count),
    .frames_due     (frames_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Build sync, type, words and the trailing XOR byte in frame_buf.
  function automatic void build_frame(input bit gain, input logic [15:0] wa, input logic [15:0] wb,
                                      input logic [15:0] wc, input logic [15:0] wd);
    logic [7:0] sum;
    frame_buf.delete();
    frame_buf.push_back(SYNC_HI);
    frame_buf.push_back(SYNC_LO);
    frame_buf.push_back(gain ? TYPE_GAIN : TYPE_WHEEL);
    frame_buf.push_back(wa[15:8]);
    frame_buf.push_back(wa[7:0]);
    frame_buf.push_back(wb[15:8]);
    frame_buf.push_back(wb[7:0]);
    frame_buf.push_back(wc[15:8]);
    frame_buf.push_back(wc[7:0]);
    if (!gain) begin
      frame_buf.push_back(wd[15:8]);
      frame_buf.push_back(wd[7:0]);
    end
    sum = 8'h00;
    foreach (frame_buf[i]) sum ^= frame_buf[i];
    frame_buf.push_back(sum);
  endfunction

  task automatic send_queued();
    int gap;
    while (tx_q.size() != 0) begin
      gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_rx_byte <= tx_q.pop_front();
      @(posedge clk);
      while (in_stall) @(posedge clk);
      bytes_sent++;
    end
  endtask

  initial begin : stimulus
    logic [15:0] w [4];
    int          pick;
    int          pos;
    int          keep;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unknown type ahead of a wheel frame, then a gain frame; mostly corner words
    tx_q.push_back(SYNC_HI);
    tx_q.push_back(SYNC_LO);
    tx_q.push_back(8'h02);
    build_frame(1'b0, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
    foreach (frame_buf[i]) tx_q.push_back(frame_buf[i]);
    build_frame(1'b1, 16'h0001, 16'h8000, 16'h7FFF, 16'h0000);
    foreach (frame_buf[i]) tx_q.push_back(frame_buf[i]);
    send_queued();

    while (bytes_sent < BYTE_TARGET) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        foreach (w[i]) w[i] = ($urandom_range(0, 7) == 0) ?
                              corner_words[$urandom_range(0, 3)] : 16'($urandom);
        build_frame(1'($urandom_range(0, 1)), w[0], w[1], w[2], w[3]);
        if (pick >= 75) begin
          // cut the frame short
          keep = $urandom_range(1, frame_buf.size() - 1);
          while (frame_buf.size() > keep) void'(frame_buf.pop_back());
        end else if (pick >= 60) begin
          // flip one bit anywhere: sync, type, payload or checksum
          pos = $urandom_range(0, frame_buf.size() - 1);
          frame_buf[pos] ^= 8'(1 << $urandom_range(0, 7));
        end
        foreach (frame_buf[i]) tx_q.push_back(frame_buf[i]);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          tx_q.push_back(($urandom_range(0, 1) == 0) ?
                         marker_bytes[$urandom_range(0, 3)] : 8'($urandom));
        end
      end
      send_queued();
    end
    in_valid <= 1'b0;

    while (frames_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && frames_due == 0) begin
      $display("** sync_xor_frame_parser: PASSED **");
    end else begin
      $display("** sync_xor_frame_parser: FAILED **");
    end
    $finish;
  end

  initial begin : receiver
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (frames_taken % 8 == 0) rx_idle = ($urandom_range(0, 2) != 0);
      // hold off once for a long stretch so the block backs up into its input
      gap = (frames_taken == HOLD_AT) ? HOLD_CYCLES :
            (rx_idle ? $urandom_range(0, MAX_GAP) : 0);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      frames_taken++;
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("** sync_xor_frame_parser: FAILED **");
    $finish;
  end

endmodule
